// ===== design/dtfw_pkg.sv =====
`timescale 1ns / 1ps
package dtfw_pkg;

	// defaults for the top level parameters
	localparam int FRAME_WIDTH_DEF  = 256;
	localparam int FRAME_HEIGHT_DEF = 256;
	localparam int DEPTH_BITS_DEF   = 24;

	// fixed field widths
	localparam int COORD_W    = 10;
	localparam int IO_DEPTH_W = 24;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int LIN_W      = 2 * COORD_W;
	localparam int S_DATA_W   = 72;
	localparam int M_DATA_W   = 56;

	// small queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_WRITTEN = 2'd0,
		ST_FAILED  = 2'd1,
		ST_RANGE   = 2'd2,
		ST_READ    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK,
		BK_DECIDE
	} bk_state_t;

	// classification made by the front
	typedef struct packed {
		logic is_read;
		logic in_range;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

// ===== design/dtfw_front.sv =====
`timescale 1ns / 1ps
module dtfw_front #(
	parameter int FRAME_WIDTH  = dtfw_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = dtfw_pkg::FRAME_HEIGHT_DEF,
	parameter int DEPTH_BITS   = dtfw_pkg::DEPTH_BITS_DEF,
	parameter int ADDR_W       = 16,
	parameter int ENTRY_W      = 66
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,
	input  logic [dtfw_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          clearing,
	input  logic                          q_ready,
	output logic                          q_push,
	output logic [ENTRY_W-1:0]            q_data
);
	import dtfw_pkg::*;

	localparam logic signed [32:0] DEPTH_MAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] DEPTH_MIN = -DEPTH_MAX - 33'sd1;

	logic [COORD_W-1:0]           x_coord;
	logic [COORD_W-1:0]           y_coord;
	logic signed [IO_DEPTH_W-1:0] frag_depth;
	logic [COLOR_W-1:0]           color;
	logic [LIN_W-1:0]             lin;
	logic signed [32:0]           depth_ext;
	logic signed [32:0]           depth_sat;
	logic [ADDR_W-1:0]            addr;
	cls_t                         cls;

	assign x_coord    = s_tdata[9:0];
	assign y_coord    = s_tdata[19:10];
	assign frag_depth = s_tdata[43:20];
	// packed red, green, blue from the top byte down
	assign color      = {s_tdata[51:44], s_tdata[59:52], s_tdata[67:60]};

	assign s_tready = !clearing && q_ready;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		cls.is_read  = (action_t'(s_tuser) == ACT_READ);
		cls.in_range = ({1'b0, x_coord} < 11'(FRAME_WIDTH))
			&& ({1'b0, y_coord} < 11'(FRAME_HEIGHT));
		lin  = LIN_W'(y_coord) * LIN_W'(FRAME_WIDTH) + LIN_W'(x_coord);
		addr = cls.in_range ? ADDR_W'(lin) : '0;
	end

	// saturate the incoming depth into the stored width
	always_comb begin
		depth_ext = 33'(frag_depth);
		if (depth_ext > DEPTH_MAX) begin
			depth_sat = DEPTH_MAX;
		end else if (depth_ext < DEPTH_MIN) begin
			depth_sat = DEPTH_MIN;
		end else begin
			depth_sat = depth_ext;
		end
	end

	assign q_data = {color, DEPTH_BITS'(depth_sat), addr, cls};

endmodule

// ===== design/dtfw_queue.sv =====
`timescale 1ns / 1ps
module dtfw_queue #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);
	import dtfw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/dtfw_back.sv =====
`timescale 1ns / 1ps
module dtfw_back #(
	parameter int FRAME_WIDTH  = dtfw_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = dtfw_pkg::FRAME_HEIGHT_DEF,
	parameter int DEPTH_BITS   = dtfw_pkg::DEPTH_BITS_DEF,
	parameter int ADDR_W       = 16,
	parameter int ENTRY_W      = 66
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [ENTRY_W-1:0]            q_data,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dtfw_pkg::M_DATA_W-1:0] m_tdata
);
	import dtfw_pkg::*;

	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = {1'b1, {(DEPTH_BITS - 1){1'b0}}};
	localparam logic signed [32:0] OUT_MAX = 33'sd8388607;
	localparam logic signed [32:0] OUT_MIN = -33'sd8388608;

	logic [COLOR_W-1:0]    color_mem [PIXELS];
	logic [DEPTH_BITS-1:0] depth_mem [PIXELS];

	bk_state_t state_q, state_d;

	logic [ADDR_W-1:0]            clr_addr_q;
	cls_t                         item_cls_q;
	logic [ADDR_W-1:0]            item_addr_q;
	logic signed [DEPTH_BITS-1:0] item_depth_q;
	logic [COLOR_W-1:0]           item_color_q;
	logic [COLOR_W-1:0]           rd_color_q;
	logic signed [DEPTH_BITS-1:0] rd_depth_q;
	logic                         m_tvalid_q;
	logic [M_DATA_W-1:0]          m_tdata_q;

	logic                  clr_last;
	logic                  out_free;
	logic                  pass;
	logic                  load_out;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [COLOR_W-1:0]    wr_color;
	logic [DEPTH_BITS-1:0] wr_depth;
	status_t               status;
	logic signed [32:0]    rd_ext;
	logic signed [32:0]    rd_sat;
	logic [M_DATA_W-1:0]   out_data;

	assign clr_last = (clr_addr_q == ADDR_W'(PIXELS - 1));
	assign out_free = !m_tvalid_q || m_tready;
	assign pass     = (item_depth_q > rd_depth_q);
	assign clearing = (state_q == BK_CLEAR);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_last) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) state_d = BK_LOOK;
			end
			BK_LOOK: begin
				state_d = BK_DECIDE;
			end
			BK_DECIDE: begin
				if (out_free) state_d = q_valid ? BK_LOOK : BK_IDLE;
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = item_addr_q;
		wr_color = item_color_q;
		wr_depth = item_depth_q;
		unique case (state_q)
			BK_CLEAR: begin
				wr_en    = 1'b1;
				wr_addr  = clr_addr_q;
				wr_color = '0;
				wr_depth = DEPTH_RESET;
			end
			BK_IDLE: begin
				q_pop = q_valid;
			end
			BK_LOOK: begin
			end
			BK_DECIDE: begin
				if (out_free) begin
					load_out = 1'b1;
					wr_en    = !item_cls_q.is_read && item_cls_q.in_range && pass;
					q_pop    = q_valid;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		priority if (!item_cls_q.in_range) begin
			status = ST_RANGE;
		end else if (item_cls_q.is_read) begin
			status = ST_READ;
		end else if (pass) begin
			status = ST_WRITTEN;
		end else begin
			status = ST_FAILED;
		end
	end

	// stored depth saturated into the 24-bit result range
	always_comb begin
		rd_ext = 33'(rd_depth_q);
		if (rd_ext > OUT_MAX) begin
			rd_sat = OUT_MAX;
		end else if (rd_ext < OUT_MIN) begin
			rd_sat = OUT_MIN;
		end else begin
			rd_sat = rd_ext;
		end
	end

	always_comb begin
		out_data = '0;
		out_data[1:0] = status;
		if (status == ST_READ) begin
			out_data[9:2]   = rd_color_q[23:16];
			out_data[17:10] = rd_color_q[15:8];
			out_data[25:18] = rd_color_q[7:0];
			out_data[49:26] = IO_DEPTH_W'(rd_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			color_mem[wr_addr] <= wr_color;
		end
		rd_color_q <= color_mem[item_addr_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			depth_mem[wr_addr] <= wr_depth;
		end
		rd_depth_q <= depth_mem[item_addr_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_cls_q   <= q_data[CLS_W-1:0];
			item_addr_q  <= q_data[CLS_W +: ADDR_W];
			item_depth_q <= q_data[CLS_W + ADDR_W +: DEPTH_BITS];
			item_color_q <= q_data[CLS_W + ADDR_W + DEPTH_BITS +: COLOR_W];
		end
		if (load_out) begin
			m_tdata_q <= out_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR && !clr_last) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == BK_CLEAR || state_q == BK_DECIDE))
		else $error("store written outside clear or decide");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result overwritten before taken");

	a_look_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_LOOK |=> state_q == BK_DECIDE)
		else $error("lookup not followed by decision");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |-> !q_pop && !load_out)
		else $error("item handled during clear");
`endif

endmodule

// ===== design/depth_tested_fragment_write_top.sv =====
`timescale 1ns / 1ps
// z-buffer depth test with read back: one result for each fragment or read request
// result path: queue, store lookup, depth decision, then the result register; a held result stalls the decision
// the back handles one request at a time through its lookup and decide steps, never overlapped
// reset: arst_n async low; afterwards a clear pass writes black and most negative depth
// into every pixel, s_tready low meanwhile
module depth_tested_fragment_write_top #(
	parameter int FRAME_WIDTH  = dtfw_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = dtfw_pkg::FRAME_HEIGHT_DEF,
	parameter int DEPTH_BITS   = dtfw_pkg::DEPTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,  // action
	// x_coord[9:0], y_coord[19:10], frag_depth[43:20], red[51:44], green[59:52],
	// blue[67:60], zero fill[71:68]
	input  logic [dtfw_pkg::S_DATA_W-1:0] s_tdata,
	// result side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], read_red[9:2], read_green[17:10], read_blue[25:18],
	// read_depth[49:26], zero fill[55:50]
	output logic [dtfw_pkg::M_DATA_W-1:0] m_tdata
);
	import dtfw_pkg::*;

	localparam int PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
	// pixel index width, kept at least one bit for a single-pixel frame
	localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	// queue entry: class flags, pixel index, saturated depth, packed color
	localparam int ENTRY_W = CLS_W + ADDR_W + DEPTH_BITS + COLOR_W;

	logic               clearing;
	logic               q_push;
	logic               q_ready;
	logic               q_pop;
	logic               q_valid;
	logic [ENTRY_W-1:0] q_in;
	logic [ENTRY_W-1:0] q_out;

	// front: range check, pixel index, depth saturation
	dtfw_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.DEPTH_BITS   (DEPTH_BITS),
		.ADDR_W       (ADDR_W),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.clearing (clearing),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	// short queue so the front keeps taking requests while the back works
	dtfw_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	// back: store lookup, depth compare, write, result register
	dtfw_back #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.DEPTH_BITS   (DEPTH_BITS),
		.ADDR_W       (ADDR_W),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
